// ===== hdl/bca_pkg.sv =====
`timescale 1ns / 1ps
package bca_pkg;

    localparam int CW = 18;          // coordinate width, 4 fraction bits
    localparam int QW = 15;          // Q1.15 normalised offset magnitude
    localparam int CFG_IW = 3;       // configuration index width
    localparam int POSW = 16;        // row and column packed
    localparam int WORDW = 4 * CW + POSW;

    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_LOAD     = 2'd1;
    localparam logic [1:0] OP_CLASSIFY = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    localparam logic [CFG_IW-1:0] CFG_LEFT   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_TOP    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_RIGHT  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_BOTTOM = 3'd3;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [CW:0]   t_dcoord;

    // One decoded item as it travels from the front part to the back part.
    typedef struct packed {
        logic [1:0] op;
        t_coord     left;
        t_coord     top;
        t_coord     right;
        t_coord     bottom;
        logic [7:0] row;
        logic [7:0] column;
        logic       act;      // classify with text and a valid token box
        logic       in_tbl;   // token centre inside a valid table box
        t_dcoord    cx;       // doubled token centre
        t_dcoord    cy;
    } t_item;

    typedef struct packed {
        logic [5:0]  cell_index;
        logic        assigned;
        logic        ambiguous;
        logic        unassigned_in_table;
        logic [6:0]  candidate_count;
        logic        store_full;
        logic [31:0] assigned_total;
        logic [31:0] ambiguous_total;
        logic [31:0] unassigned_total;
    } t_res;

endpackage

// ===== hdl/bca_ram.sv =====
`timescale 1ns / 1ps
module bca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bca_div.sv =====
`timescale 1ns / 1ps
module bca_div
    import bca_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_mag,
    input  logic [CW-1:0] i_size,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);

    // Restoring division of mag * 2^14 by size with mag no larger than size,
    // one quotient bit per cycle, most significant first.
    localparam int CNTW = $clog2(QW);

    logic [CW-1:0]   r_rem;
    logic [CW-1:0]   r_size;
    logic [QW-1:0]   r_quot;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_first;
    logic            r_done;
    logic [CW:0]     trial;
    logic            ge;
    logic [CW:0]     diff;

    always_comb begin
        trial = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};
        ge    = trial >= {1'b0, r_size};
        diff  = trial - {1'b0, r_size};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_first <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_first <= 1'b1;
                r_cnt <= CNTW'(QW - 1);
            end else if (r_busy) begin
                r_first <= 1'b0;
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_mag;
            r_size <= i_size;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[CW-1:0] : trial[CW-1:0];
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hdl/bca_front.sv =====
`timescale 1ns / 1ps
module bca_front
    import bca_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_operation,
    input  t_coord     i_left,
    input  t_coord     i_top,
    input  t_coord     i_right,
    input  t_coord     i_bottom,
    input  logic [7:0] i_row,
    input  logic [7:0] i_column,
    input  logic       i_has_text,
    input  t_coord     i_tbl_left,
    input  t_coord     i_tbl_top,
    input  t_coord     i_tbl_right,
    input  t_coord     i_tbl_bottom,
    output logic       o_head_valid,
    output t_item      o_head,
    input  logic       i_pop
);

    t_item      dec;
    logic       push;
    logic       tbl_ok;
    logic       tk_ok;
    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // Decode the item and settle the table test here; the user must change
    // the table registers only while idle, which the block does not enforce.
    always_comb begin
        dec.op     = i_operation;
        dec.left   = i_left;
        dec.top    = i_top;
        dec.right  = i_right;
        dec.bottom = i_bottom;
        dec.row    = i_row;
        dec.column = i_column;
        dec.cx     = {i_left[CW-1], i_left} + {i_right[CW-1], i_right};
        dec.cy     = {i_top[CW-1], i_top} + {i_bottom[CW-1], i_bottom};
        tk_ok      = (i_right > i_left) && (i_bottom > i_top);
        tbl_ok     = (i_tbl_right > i_tbl_left) && (i_tbl_bottom > i_tbl_top);
        dec.act    = (i_operation == OP_CLASSIFY) && i_has_text && tk_ok;
        dec.in_tbl = tbl_ok
            && (dec.cx >= $signed({i_tbl_left, 1'b0}))
            && (dec.cx <= $signed({i_tbl_right, 1'b0}))
            && (dec.cy >= $signed({i_tbl_top, 1'b0}))
            && (dec.cy <= $signed({i_tbl_bottom, 1'b0}));
    end

    assign o_stall      = (r_cnt == 2'd2);
    assign push         = i_valid && !o_stall;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule

// ===== hdl/bca_back.sv =====
`timescale 1ns / 1ps
module bca_back
    import bca_pkg::*;
#(
    parameter int MAX_CELLS = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_item_valid,
    input  t_item i_item,
    output logic  o_pop,
    input  logic  i_out_stall,
    output logic  o_out_valid,
    output t_res  o_res
);

    localparam int IW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int LW = $clog2(MAX_CELLS + 1);
    localparam int AW = 2 * CW;
    localparam int DW = 2 * QW + 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_EVAL = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_CMP  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    t_item         r_item;
    logic [LW-1:0] r_loaded;
    logic [LW-1:0] r_scan;
    logic [6:0]    r_cnt;
    logic          r_have;
    logic [IW-1:0] r_best;
    logic [AW-1:0] r_barea;
    logic [DW-1:0] r_bdist;
    logic [15:0]   r_bpos;
    logic [CW-1:0] r_ovx;
    logic [CW-1:0] r_ovy;
    logic [15:0]   r_pos;
    logic [AW-1:0] r_area;
    logic [2*QW-1:0] r_sqx;
    logic [2*QW-1:0] r_sqy;
    logic [31:0]   r_asg_tot;
    logic [31:0]   r_amb_tot;
    logic [31:0]   r_uin_tot;
    t_res          r_res;
    logic          r_o_valid;

    logic [WORDW-1:0] rd_data;
    logic [WORDW-1:0] wr_data;
    logic          ram_we;
    t_coord        cl, cr, ct, cb;
    logic          c_valid, cand;
    t_coord        lo_x, hi_x, lo_y, hi_y;
    logic [CW:0]   sp_x, sp_y;
    logic [CW+1:0] csum_x, csum_y, d2x, d2y, abs_x, abs_y;
    logic [CW-1:0] size_x, size_y;
    logic          div_start, div_done, div_done_y;
    logic [QW-1:0] qx, qy;
    logic [DW-1:0] sq_dist;
    logic          better;
    logic [LW-1:0] scan_nx;
    logic          last;
    logic          take;
    logic          full;
    t_res          res;

    // Cell word: right, left, bottom, top, row, column.
    assign cl = rd_data[POSW+2*CW +: CW];
    assign cr = rd_data[POSW+3*CW +: CW];
    assign ct = rd_data[POSW +: CW];
    assign cb = rd_data[POSW+CW +: CW];

    always_comb begin
        c_valid = (cr > cl) && (cb > ct);
        cand = c_valid
            && (r_item.cx >= $signed({cl, 1'b0})) && (r_item.cx <= $signed({cr, 1'b0}))
            && (r_item.cy >= $signed({ct, 1'b0})) && (r_item.cy <= $signed({cb, 1'b0}));
        lo_x = (cl > r_item.left) ? cl : r_item.left;
        hi_x = (cr < r_item.right) ? cr : r_item.right;
        lo_y = (ct > r_item.top) ? ct : r_item.top;
        hi_y = (cb < r_item.bottom) ? cb : r_item.bottom;
        sp_x = {hi_x[CW-1], hi_x} - {lo_x[CW-1], lo_x};
        sp_y = {hi_y[CW-1], hi_y} - {lo_y[CW-1], lo_y};
        csum_x = {{2{cl[CW-1]}}, cl} + {{2{cr[CW-1]}}, cr};
        csum_y = {{2{ct[CW-1]}}, ct} + {{2{cb[CW-1]}}, cb};
        d2x = {r_item.cx[CW], r_item.cx} - csum_x;
        d2y = {r_item.cy[CW], r_item.cy} - csum_y;
        abs_x = d2x[CW+1] ? -d2x : d2x;
        abs_y = d2y[CW+1] ? -d2y : d2y;
        size_x = CW'(cr - cl);
        size_y = CW'(cb - ct);
    end

    assign div_start = (r_state == S_EVAL) && cand;

    bca_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (abs_x[CW-1:0]),
        .i_size  (size_x),
        .o_done  (div_done),
        .o_quot  (qx)
    );

    bca_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (abs_y[CW-1:0]),
        .i_size  (size_y),
        .o_done  (div_done_y),
        .o_quot  (qy)
    );

    // Ranking: larger area, then smaller distance, then smaller position.
    always_comb begin
        sq_dist = {1'b0, r_sqx} + {1'b0, r_sqy};
        if (!r_have) begin
            better = 1'b1;
        end else if (r_area != r_barea) begin
            better = r_area > r_barea;
        end else if (sq_dist != r_bdist) begin
            better = sq_dist < r_bdist;
        end else begin
            better = r_pos < r_bpos;
        end
    end

    assign scan_nx = r_scan + LW'(1);
    assign last    = (scan_nx == r_loaded);
    assign o_pop   = (r_state == S_IDLE) && i_item_valid;
    assign take    = (r_state == S_DONE) && (!r_o_valid || !i_out_stall);
    assign full    = (r_loaded == LW'(MAX_CELLS));
    assign ram_we  = take && (r_item.op == OP_LOAD) && !full;
    assign wr_data = {r_item.right, r_item.left, r_item.bottom, r_item.top,
                      r_item.row, r_item.column};

    bca_ram #(
        .WIDTH (WORDW),
        .DEPTH (MAX_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_loaded[IW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (r_scan[IW-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.op == OP_CLASSIFY && i_item.act && r_loaded != '0) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                if (cand) begin
                    n_state = S_DIV;
                end else begin
                    n_state = last ? S_DONE : S_READ;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_CMP;
            S_CMP: n_state = last ? S_DONE : S_READ;
            S_DONE: begin
                if (take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        res = '0;
        res.assigned_total   = r_asg_tot;
        res.ambiguous_total  = r_amb_tot;
        res.unassigned_total = r_uin_tot;
        case (r_item.op)
            OP_CLEAR: begin
                res.assigned_total   = '0;
                res.ambiguous_total  = '0;
                res.unassigned_total = '0;
            end
            OP_LOAD: begin
                res.store_full = full;
                res.cell_index = full ? 6'd0 : 6'(r_loaded[IW-1:0]);
            end
            OP_CLASSIFY: begin
                if (r_item.act) begin
                    res.candidate_count = r_cnt;
                    if (r_have) begin
                        res.cell_index = 6'(r_best);
                        res.assigned = 1'b1;
                        res.ambiguous = (r_cnt > 7'd1);
                        if (r_asg_tot != '1) begin
                            res.assigned_total = r_asg_tot + 32'd1;
                        end
                        if (r_cnt > 7'd1 && r_amb_tot != '1) begin
                            res.ambiguous_total = r_amb_tot + 32'd1;
                        end
                    end else if (r_item.in_tbl) begin
                        res.unassigned_in_table = 1'b1;
                        if (r_uin_tot != '1) begin
                            res.unassigned_total = r_uin_tot + 32'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_loaded  <= '0;
            r_asg_tot <= '0;
            r_amb_tot <= '0;
            r_uin_tot <= '0;
            r_o_valid <= 1'b0;
            r_have    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_have <= 1'b0;
                r_cnt  <= '0;
            end
            if (div_start && r_cnt != 7'h7f) begin
                r_cnt <= r_cnt + 7'd1;
            end
            if (r_state == S_CMP && better) begin
                r_have <= 1'b1;
            end
            if (take) begin
                r_o_valid <= 1'b1;
                r_asg_tot <= res.assigned_total;
                r_amb_tot <= res.ambiguous_total;
                r_uin_tot <= res.unassigned_total;
                if (r_item.op == OP_CLEAR) begin
                    r_loaded <= '0;
                end else if (ram_we) begin
                    r_loaded <= r_loaded + LW'(1);
                end
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
            r_scan <= '0;
        end
        if (r_state == S_EVAL) begin
            r_ovx <= (hi_x > lo_x) ? sp_x[CW-1:0] : '0;
            r_ovy <= (hi_y > lo_y) ? sp_y[CW-1:0] : '0;
            r_pos <= rd_data[POSW-1:0];
            if (!cand) begin
                r_scan <= scan_nx;
            end
        end
        if (r_state == S_MUL) begin
            r_area <= r_ovx * r_ovy;
            r_sqx  <= qx * qx;
            r_sqy  <= qy * qy;
        end
        if (r_state == S_CMP) begin
            r_scan <= scan_nx;
            if (better) begin
                r_best  <= r_scan[IW-1:0];
                r_barea <= r_area;
                r_bdist <= sq_dist;
                r_bpos  <= r_pos;
            end
        end
        if (take) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_res       = r_res;

    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= LW'(MAX_CELLS))
        else $error("cell count beyond store depth");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_loaded < LW'(MAX_CELLS)))
        else $error("cell write into a full store");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV) && div_done_y)
        else $error("divider finished outside the division state");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_scan < r_loaded))
        else $error("scan reads beyond the loaded cells");

endmodule

// ===== hdl/box_to_cell_assigner_core.sv =====
`timescale 1ns / 1ps
// Box to cell assigner. Items arrive on the input channel (i_in_valid, o_in_stall);
// each beat carries an operation: clear the cells and counters, load one cell
// box with its row and column, classify one token box, or do nothing.
// Every beat gives exactly one result beat on the output channel
// (o_out_valid, i_out_stall), in order.
// The user must write the table box via the configuration port only while idle;
// the block does not enforce it. o_cfg_ready is always high and indexes above
// three are ignored. A two-beat queue sits between the decoding front and the
// execution engine, so inputs keep being taken while a result waits in the output
// register. Clear, load and no-operation beats go straight to the result.
// A classify beat scans the loaded cells one after another through the cell
// memory port: a cell that does not hold the token centre is read and evaluated;
// one that does also waits on the bit-serial Q1.15 divisions, run for x and y
// side by side, then on the multiply and compare steps.
// Reset (i_rst_n low at a clock edge) empties the store, zeroes the counters
// and the table box; the cell memory needs no clearing pass.
// While i_out_stall is high the result holds, the engine waits with its next
// result, and the queue fills, after which o_in_stall rises.
module box_to_cell_assigner_core
    import bca_pkg::*;
#(
    parameter int MAX_CELLS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_operation,
    input  logic signed [17:0] i_box_left,
    input  logic signed [17:0] i_box_top,
    input  logic signed [17:0] i_box_right,
    input  logic signed [17:0] i_box_bottom,
    input  logic [7:0]        i_cell_row,
    input  logic [7:0]        i_cell_column,
    input  logic              i_token_has_text,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [5:0]        o_cell_index,
    output logic              o_assigned,
    output logic              o_ambiguous,
    output logic              o_unassigned_in_table,
    output logic [6:0]        o_candidate_count,
    output logic              o_store_full,
    output logic [31:0]       o_assigned_total,
    output logic [31:0]       o_ambiguous_total,
    output logic [31:0]       o_unassigned_total,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [17:0]       i_cfg_data
);

    t_coord r_tbl_left;
    t_coord r_tbl_top;
    t_coord r_tbl_right;
    t_coord r_tbl_bottom;
    logic   head_valid;
    t_item  head;
    logic   pop;
    t_res   res;

    assign o_cfg_ready = 1'b1;

    // Table box registers. A reset value of zero makes the box invalid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_left   <= '0;
            r_tbl_top    <= '0;
            r_tbl_right  <= '0;
            r_tbl_bottom <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LEFT:   r_tbl_left   <= i_cfg_data;
                CFG_TOP:    r_tbl_top    <= i_cfg_data;
                CFG_RIGHT:  r_tbl_right  <= i_cfg_data;
                CFG_BOTTOM: r_tbl_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front decodes each beat and queues it.
    bca_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_operation  (i_operation),
        .i_left       (i_box_left),
        .i_top        (i_box_top),
        .i_right      (i_box_right),
        .i_bottom     (i_box_bottom),
        .i_row        (i_cell_row),
        .i_column     (i_cell_column),
        .i_has_text   (i_token_has_text),
        .i_tbl_left   (r_tbl_left),
        .i_tbl_top    (r_tbl_top),
        .i_tbl_right  (r_tbl_right),
        .i_tbl_bottom (r_tbl_bottom),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // The back owns the cell store, the scan and the counters.
    bca_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (head_valid),
        .i_item       (head),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_res        (res)
    );

    assign o_cell_index          = res.cell_index;
    assign o_assigned            = res.assigned;
    assign o_ambiguous           = res.ambiguous;
    assign o_unassigned_in_table = res.unassigned_in_table;
    assign o_candidate_count     = res.candidate_count;
    assign o_store_full          = res.store_full;
    assign o_assigned_total      = res.assigned_total;
    assign o_ambiguous_total     = res.ambiguous_total;
    assign o_unassigned_total    = res.unassigned_total;

endmodule

// ===== dv/box_to_cell_assigner_core_tb.sv =====
`timescale 1ns / 1ps
module box_to_cell_assigner_core_tb;
    import bca_pkg::*;

    localparam int NCELLS = 64;
    localparam logic [31:0] CNT_TOP = 32'hFFFF_FFFF;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_operation;
    logic signed [17:0] i_box_left, i_box_top, i_box_right, i_box_bottom;
    logic [7:0]        i_cell_row, i_cell_column;
    logic              i_token_has_text;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [5:0]        o_cell_index;
    logic              o_assigned, o_ambiguous, o_unassigned_in_table;
    logic [6:0]        o_candidate_count;
    logic              o_store_full;
    logic [31:0]       o_assigned_total, o_ambiguous_total, o_unassigned_total;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [17:0]       i_cfg_data;

    box_to_cell_assigner_core i_dut (.*);

    // The shadow copy of the block: cell store, counters and the table box.
    t_coord      cell_l[NCELLS], cell_t[NCELLS], cell_r[NCELLS], cell_b[NCELLS];
    logic [15:0] cell_pos[NCELLS];
    int          n_loaded;
    logic [31:0] cnt_asg, cnt_amb, cnt_uin;
    t_coord      tbl[4];

    t_res        pending_results[$];
    int          n_errors;
    bit          idle_on;
    bit          hold_out;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic bit is_valid_box(input t_coord l, t, r, b);
        return (r > l) && (b > t);
    endfunction

    // Centre of the token box in doubled units, edges count as inside.
    function automatic bit holds_centre(input t_coord l, t, r, b,
                                        input longint cx, cy);
        return cx >= 2 * longint'(l) && cx <= 2 * longint'(r) &&
               cy >= 2 * longint'(t) && cy <= 2 * longint'(b);
    endfunction

    function automatic longint span_overlap(input longint a0, a1, b0, b1);
        longint lo, hi;
        lo = a0 > b0 ? a0 : b0;
        hi = a1 < b1 ? a1 : b1;
        return hi > lo ? hi - lo : 0;
    endfunction

    // Q1.15 of d2 / (2 * size), truncated toward zero.
    function automatic longint offset_q15(input longint d2, input longint size);
        longint mag;
        mag = d2 < 0 ? -d2 : d2;
        mag = (mag <<< 14) / size;
        return d2 < 0 ? -mag : mag;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return c == CNT_TOP ? c : c + 32'd1;
    endfunction

    // Works out the result beat that one input beat causes and updates the
    // shadow state.
    function automatic t_res assign_token(input logic [1:0] op, input t_coord l, t, r, b,
                                          input logic [7:0] row, col, input logic txt);
        t_res   res;
        bit     have;
        int     cnt, best;
        longint cx, cy, area, dx, dy, sq_dist, b_area, b_dist;
        logic [15:0] b_pos;
        bit     better;
        res = '0;
        have = 0; cnt = 0; best = 0; b_area = 0; b_dist = 0; b_pos = 0;
        cx = longint'(l) + longint'(r);
        cy = longint'(t) + longint'(b);
        if (op == OP_CLEAR) begin
            n_loaded = 0;
            cnt_asg = 0; cnt_amb = 0; cnt_uin = 0;
        end else if (op == OP_LOAD) begin
            if (n_loaded >= NCELLS) begin
                res.store_full = 1'b1;
            end else begin
                cell_l[n_loaded] = l; cell_t[n_loaded] = t;
                cell_r[n_loaded] = r; cell_b[n_loaded] = b;
                cell_pos[n_loaded] = {row, col};
                res.cell_index = n_loaded[5:0];
                n_loaded++;
            end
        end else if (op == OP_CLASSIFY && txt && is_valid_box(l, t, r, b)) begin
            for (int i = 0; i < n_loaded; i++) begin
                if (!is_valid_box(cell_l[i], cell_t[i], cell_r[i], cell_b[i]) ||
                    !holds_centre(cell_l[i], cell_t[i], cell_r[i], cell_b[i], cx, cy))
                    continue;
                cnt++;
                area = span_overlap(cell_l[i], cell_r[i], l, r) *
                       span_overlap(cell_t[i], cell_b[i], t, b);
                dx = offset_q15(cx - (longint'(cell_l[i]) + cell_r[i]),
                                longint'(cell_r[i]) - cell_l[i]);
                dy = offset_q15(cy - (longint'(cell_t[i]) + cell_b[i]),
                                longint'(cell_b[i]) - cell_t[i]);
                sq_dist = dx * dx + dy * dy;
                if (!have) better = 1;
                else if (area != b_area) better = area > b_area;
                else if (sq_dist != b_dist) better = sq_dist < b_dist;
                else better = cell_pos[i] < b_pos;
                if (better) begin
                    have = 1; best = i;
                    b_area = area; b_dist = sq_dist; b_pos = cell_pos[i];
                end
            end
            res.candidate_count = cnt[6:0];
            if (have) begin
                res.cell_index = best[5:0];
                res.assigned = 1'b1;
                cnt_asg = sat_inc(cnt_asg);
                if (cnt > 1) begin
                    res.ambiguous = 1'b1;
                    cnt_amb = sat_inc(cnt_amb);
                end
            end else if (is_valid_box(tbl[0], tbl[1], tbl[2], tbl[3]) &&
                         holds_centre(tbl[0], tbl[1], tbl[2], tbl[3], cx, cy)) begin
                res.unassigned_in_table = 1'b1;
                cnt_uin = sat_inc(cnt_uin);
            end
        end
        res.assigned_total = cnt_asg;
        res.ambiguous_total = cnt_amb;
        res.unassigned_total = cnt_uin;
        return res;
    endfunction

    // Sends one beat; the expectation is queued at the edge that accepts it.
    // Valid stays high afterwards so that beats can follow back to back; it
    // drops during an idle gap or when the sender stops.
    task automatic send_beat(input logic [1:0] op, input t_coord l, t, r, b,
                             input logic [7:0] row = 0, col = 0, input logic txt = 1);
        t_res want;
        while (idle_on && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_box_left <= l; i_box_top <= t; i_box_right <= r; i_box_bottom <= b;
        i_cell_row <= row; i_cell_column <= col; i_token_has_text <= txt;
        do @(posedge i_clk); while (o_in_stall);
        want = assign_token(op, l, t, r, b, row, col, txt);
        pending_results.insert(pending_results.size(), want);
        @(negedge i_clk);
    endtask

    // Stops the sender, waits for the last expectation, then lets the engine
    // settle before a register write.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [17:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= CFG_BOTTOM) tbl[idx[1:0]] = val;
        @(negedge i_clk);
    endtask

    task automatic set_table(input t_coord l, t, r, b);
        drain();
        write_reg(CFG_LEFT, l);
        write_reg(CFG_TOP, t);
        write_reg(CFG_RIGHT, r);
        write_reg(CFG_BOTTOM, b);
        // An index past the last register must change nothing.
        write_reg(3'd5, 18'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_coord rnd_coord;
        return t_coord'($urandom);
    endfunction

    // Output checker: each result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing expected", 32'd1, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_cell_index != want.cell_index)
                    report_mismatch("cell_index", 32'(o_cell_index), 32'(want.cell_index));
                if (o_assigned != want.assigned)
                    report_mismatch("assigned", 32'(o_assigned), 32'(want.assigned));
                if (o_ambiguous != want.ambiguous)
                    report_mismatch("ambiguous", 32'(o_ambiguous), 32'(want.ambiguous));
                if (o_unassigned_in_table != want.unassigned_in_table)
                    report_mismatch("unassigned_in_table", 32'(o_unassigned_in_table),
                                    32'(want.unassigned_in_table));
                if (o_candidate_count != want.candidate_count)
                    report_mismatch("candidate_count", 32'(o_candidate_count),
                                    32'(want.candidate_count));
                if (o_store_full != want.store_full)
                    report_mismatch("store_full", 32'(o_store_full), 32'(want.store_full));
                if (o_assigned_total != want.assigned_total)
                    report_mismatch("assigned_total", o_assigned_total, want.assigned_total);
                if (o_ambiguous_total != want.ambiguous_total)
                    report_mismatch("ambiguous_total", o_ambiguous_total,
                                    want.ambiguous_total);
                if (o_unassigned_total != want.unassigned_total)
                    report_mismatch("unassigned_total", o_unassigned_total,
                                    want.unassigned_total);
            end
        end
    end

    // Receiver stall: random when idling is on, held high for a long stretch
    // when hold_out is set.
    always @(negedge i_clk) begin
        i_out_stall <= hold_out || (idle_on && $urandom_range(99) < 16);
    end

    task automatic hold_receiver(input int cycles);
        hold_out = 1;
        repeat (cycles) @(negedge i_clk);
        hold_out = 0;
    endtask

    // Directed part: every operation, the extremes and each special case.
    task automatic test_directed;
        send_beat(OP_NOP, 0, 0, 0, 0);
        send_beat(OP_CLASSIFY, -10, -10, 10, 10);            // empty store
        set_table(-131072, -131072, 131071, 131071);
        send_beat(OP_CLASSIFY, -10, -10, 10, 10);            // unassigned in table
        send_beat(OP_LOAD, 0, 0, 160, 160, 8'd255, 8'd0);
        send_beat(OP_LOAD, 0, 0, 320, 320, 8'd0, 8'd255);    // larger, same centre region
        send_beat(OP_LOAD, 100, 100, 100, 200, 8'd1, 8'd1);  // invalid cell box
        send_beat(OP_LOAD, 0, 0, 160, 160, 8'd255, 8'd0);    // full tie with slot 0
        send_beat(OP_CLASSIFY, 40, 40, 120, 120);            // ambiguous
        send_beat(OP_CLASSIFY, 40, 40, 120, 120, 0, 0, 1'b0); // no text
        send_beat(OP_CLASSIFY, 120, 40, 40, 120);            // invalid token box
        send_beat(OP_CLASSIFY, 150, 150, 170, 170);          // centre on an edge
        send_beat(OP_LOAD, -131072, -131072, 131071, 131071, 8'd3, 8'd3);
        send_beat(OP_CLASSIFY, -131072, -131072, 131071, 131071);
        send_beat(OP_CLASSIFY, 131070, -131072, 131071, -131071);
        send_beat(OP_NOP, 5, 5, 5, 5);
        send_beat(OP_CLEAR, 0, 0, 0, 0);
        send_beat(OP_CLASSIFY, 40, 40, 120, 120);
    endtask

    // Fills the store past its end so that the overflow case is hit.
    task automatic test_store_full;
        send_beat(OP_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < NCELLS + 3; i++)
            send_beat(OP_LOAD, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                      8'($urandom), 8'($urandom));
        send_beat(OP_CLASSIFY, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    endtask

    // Random part: a grid of cells with random content, tokens near it and
    // a share of noise beats.
    task automatic test_random(input int items);
        int     sent, ncell, gx, gy, pitch, x0, y0, cx, cy, w, h;
        t_coord tl, tt;
        sent = 0;
        while (sent < items) begin
            send_beat(OP_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
            sent++;
            ncell = $urandom_range(1, 12);
            pitch = $urandom_range(16, 2000);
            x0 = $urandom_range(0, 4000) - 2000;
            y0 = $urandom_range(0, 4000) - 2000;
            for (int i = 0; i < ncell; i++) begin
                gx = $urandom_range(0, 3);
                gy = $urandom_range(0, 3);
                w = pitch + $urandom_range(0, pitch) - pitch / 2;
                h = pitch + $urandom_range(0, pitch) - pitch / 2;
                if ($urandom_range(19) == 0) w = -w;
                send_beat(OP_LOAD, t_coord'(x0 + gx * pitch), t_coord'(y0 + gy * pitch),
                          t_coord'(x0 + gx * pitch + w), t_coord'(y0 + gy * pitch + h),
                          8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
                sent++;
            end
            for (int k = 0; k < $urandom_range(4, 16); k++) begin
                if ($urandom_range(9) == 0) begin
                    send_beat(2'($urandom_range(1, 3)), rnd_coord(), rnd_coord(),
                              rnd_coord(), rnd_coord(), 8'($urandom), 8'($urandom),
                              1'($urandom_range(1)));
                end else begin
                    cx = x0 + $urandom_range(0, 5 * pitch) - pitch;
                    cy = y0 + $urandom_range(0, 5 * pitch) - pitch;
                    w = $urandom_range(1, pitch);
                    h = $urandom_range(1, pitch);
                    tl = t_coord'(cx - w);
                    tt = t_coord'(cy - h);
                    send_beat(OP_CLASSIFY, tl, tt, t_coord'(cx + w), t_coord'(cy + h),
                              8'($urandom), 8'($urandom), $urandom_range(15) != 0);
                end
                sent++;
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering beats, then the
    // sender pauses until every result has come.
    task automatic test_backpressure;
        fork
            hold_receiver(400);
            begin
                for (int i = 0; i < 12; i++)
                    send_beat(i % 3 == 0 ? OP_LOAD : OP_CLASSIFY,
                              t_coord'($urandom_range(0, 300)),
                              t_coord'($urandom_range(0, 300)),
                              t_coord'($urandom_range(200, 600)),
                              t_coord'($urandom_range(200, 600)));
            end
        join
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0; i_operation = OP_NOP;
        i_box_left = 0; i_box_top = 0; i_box_right = 0; i_box_bottom = 0;
        i_cell_row = 0; i_cell_column = 0; i_token_has_text = 0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = CFG_LEFT; i_cfg_data = 0;
        tbl = '{default: '0};
        n_loaded = 0; cnt_asg = 0; cnt_amb = 0; cnt_uin = 0;
        n_errors = 0; idle_on = 0; hold_out = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        idle_on = 1;
        test_store_full();
        test_backpressure();
        set_table(-500, -500, 500, 500);
        test_random(450);
        set_table(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        idle_on = 0;
        test_random(300);
        idle_on = 1;
        set_table(131071, 131071, -131072, -131072);
        test_random(250);
        set_table(-3000, -3000, 3000, 3000);
        test_random(250);

        drain();
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Worst case is about 1400 beats, each of which can scan a full store.
    initial begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
